FILE: rtl/core/bpfs_pkg.sv
// Shared constants and types for the buffer pool free stack allocator.
// No dependencies.
`timescale 1ns / 1ps

package bpfs_pkg;

	localparam int NUM_BUFFERS = 16;
	localparam int IDX_W       = 4;   // buffer_index / result_index field width
	localparam int CNT_W       = 5;   // free_left field width
	localparam int STAT_W      = 3;

	localparam logic [STAT_W-1:0] ST_FREE  = 3'd0;
	localparam logic [STAT_W-1:0] ST_ALLOC = 3'd1;

	typedef enum logic [1:0] {
		REQ_ALLOC = 2'd0,
		REQ_FREE  = 2'd1,
		REQ_GET   = 2'd2,
		REQ_SET   = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ERR_OK           = 2'd0,
		ERR_EMPTY        = 2'd1,
		ERR_ALREADY_FREE = 2'd2,
		ERR_RANGE        = 2'd3
	} err_t;

	typedef enum logic {
		CTL_IDLE = 1'b0,
		CTL_EXEC = 1'b1
	} ctl_state_t;

endpackage

FILE: rtl/core/buffer_pool_free_stack_allocator.sv
// Top level of the buffer pool free stack allocator: free stack, status memory,
// control FSM and output register. Depends on bpfs_pkg.
`timescale 1ns / 1ps

// Usage
//  Requests come in on the s_ channel: s_tuser carries the request kind
//  (allocate, free, get status, set status), s_tdata the buffer index and the
//  new status. Each request gives exactly one result on the m_ channel: the
//  granted or echoed index, the buffer status after the request, an error code
//  and the number of free buffers left.
//  Flow: a request is first read: the free stack top and the addressed status
//  word are registered from the two synchronous memories. Then it is modified,
//  written back and loaded into the output register once that register is
//  free. A new request is taken only after the last one has written back.
//  Only one request is in flight, so no forwarding is needed.
//  Reset: the count is set to full and the per-entry valid bits are cleared;
//  an entry that was never written reads as its reset value (stack entry i
//  holds i, status is free). No clearing pass, so requests are taken right
//  after reset.
//  Stall: while a result waits in the output register the next request is
//  still taken and read; its write-back holds until the output register
//  frees, and s_tready stays low meanwhile.
module buffer_pool_free_stack_allocator
	import bpfs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [3:0] buffer_index, [6:4] new_status, [7] zero
	input  logic [1:0]  s_tuser,   // [1:0] req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [3:0] result_index, [6:4] status_out,
	                               // [8:7] error_code, [13:9] free_left, [15:14] zero
);

	// control state
	ctl_state_t             state_q, state_d;
	logic [CNT_W-1:0]       free_count_q;
	logic                   out_vld_q;
	logic                   accept;
	logic                   exec_go;

	// memories and their valid bits
	logic [IDX_W-1:0]       stack_mem  [NUM_BUFFERS];
	logic [STAT_W-1:0]      status_mem [NUM_BUFFERS];
	logic [NUM_BUFFERS-1:0] stack_vld_q;
	logic [NUM_BUFFERS-1:0] status_vld_q;

	// stage 1: request and read data
	req_t                   req_s1;
	logic [IDX_W-1:0]       idx_s1;
	logic [STAT_W-1:0]      nst_s1;
	logic [IDX_W-1:0]       stk_raddr_s1;
	logic [IDX_W-1:0]       stk_rdata_s1;
	logic                   stk_hit_s1;
	logic [STAT_W-1:0]      st_rdata_s1;
	logic                   st_hit_s1;

	// execute results
	logic [IDX_W-1:0]       stk_raddr;
	logic [IDX_W-1:0]       top_idx;
	logic [STAT_W-1:0]      cur_st;
	logic                   stk_we;
	logic [IDX_W-1:0]       stk_waddr;
	logic                   st_we;
	logic [IDX_W-1:0]       st_waddr;
	logic [STAT_W-1:0]      st_wdata;
	logic [CNT_W-1:0]       count_nxt;
	logic [IDX_W-1:0]       res_idx;
	logic [STAT_W-1:0]      res_st;
	err_t                   res_err;

	// output register
	logic [IDX_W-1:0]       out_idx_q;
	logic [STAT_W-1:0]      out_st_q;
	err_t                   out_err_q;
	logic [CNT_W-1:0]       out_free_q;

	// ---------------- control FSM ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CTL_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		exec_go  = 1'b0;
		unique case (state_q)
			CTL_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) state_d = CTL_EXEC;
			end
			CTL_EXEC: begin
				// write back only when the output register can take the result
				exec_go = !out_vld_q || m_tready;
				if (exec_go) state_d = CTL_IDLE;
			end
			default: state_d = CTL_IDLE;
		endcase
	end

	assign accept    = s_tvalid && s_tready;
	// top of stack sits one below the count; wraps when empty, unused then
	assign stk_raddr = IDX_W'(free_count_q - CNT_W'(1));

	// ---------------- read stage ----------------
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1       <= req_t'(s_tuser);
			idx_s1       <= s_tdata[3:0];
			nst_s1       <= s_tdata[6:4];
			stk_raddr_s1 <= stk_raddr;
			stk_rdata_s1 <= stack_mem[stk_raddr];
			stk_hit_s1   <= stack_vld_q[stk_raddr];
			st_rdata_s1  <= status_mem[s_tdata[3:0]];
			st_hit_s1    <= status_vld_q[s_tdata[3:0]];
		end
	end

	// unwritten entries read as their reset contents
	assign top_idx = stk_hit_s1 ? stk_rdata_s1 : stk_raddr_s1;
	assign cur_st  = st_hit_s1 ? st_rdata_s1 : ST_FREE;

	// ---------------- modify ----------------
	always_comb begin
		stk_we    = 1'b0;
		stk_waddr = IDX_W'(free_count_q);
		st_we     = 1'b0;
		st_waddr  = idx_s1;
		st_wdata  = nst_s1;
		count_nxt = free_count_q;
		res_idx   = idx_s1;
		res_st    = ST_FREE;
		res_err   = ERR_OK;
		if (req_s1 == REQ_ALLOC) begin
			if (free_count_q == '0 || free_count_q > CNT_W'(NUM_BUFFERS)) begin
				res_err = ERR_EMPTY;
				res_idx = '0;
			end else begin
				count_nxt = free_count_q - CNT_W'(1);
				st_we     = 1'b1;
				st_waddr  = top_idx;
				st_wdata  = ST_ALLOC;
				res_idx   = top_idx;
				res_st    = ST_ALLOC;
			end
		end else if ({1'b0, idx_s1} >= CNT_W'(NUM_BUFFERS)) begin
			res_err = ERR_RANGE;
		end else begin
			case (req_s1)
				REQ_FREE: begin
					if (cur_st == ST_FREE) begin
						res_err = ERR_ALREADY_FREE;
					end else if (free_count_q >= CNT_W'(NUM_BUFFERS)) begin
						// stack full after a set marked a stacked buffer busy
						res_err = ERR_ALREADY_FREE;
						res_st  = cur_st;
					end else begin
						stk_we    = 1'b1;
						count_nxt = free_count_q + CNT_W'(1);
						st_we     = 1'b1;
						st_wdata  = ST_FREE;
					end
				end
				REQ_GET: res_st = cur_st;
				default: begin
					st_we  = 1'b1;
					res_st = nst_s1;
				end
			endcase
		end
	end

	// ---------------- write back ----------------
	always_ff @(posedge clk) begin
		if (exec_go && stk_we) stack_mem[stk_waddr] <= idx_s1;
		if (exec_go && st_we)  status_mem[st_waddr] <= st_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_count_q <= CNT_W'(NUM_BUFFERS);
			stack_vld_q  <= '0;
			status_vld_q <= '0;
			out_vld_q    <= 1'b0;
		end else begin
			if (exec_go) begin
				free_count_q <= count_nxt;
				if (stk_we) stack_vld_q[stk_waddr] <= 1'b1;
				if (st_we)  status_vld_q[st_waddr] <= 1'b1;
			end
			if (exec_go)       out_vld_q <= 1'b1;
			else if (m_tready) out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_go) begin
			out_idx_q  <= res_idx;
			out_st_q   <= res_st;
			out_err_q  <= res_err;
			out_free_q <= count_nxt;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {2'b00, out_free_q, out_err_q, out_st_q, out_idx_q};

	// ---------------- assertions ----------------
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		free_count_q <= CNT_W'(NUM_BUFFERS))
		else $error("free count above pool size");

	a_free_left: assert property (@(posedge clk) disable iff (!arst_n)
		exec_go |=> (out_free_q == free_count_q) && m_tvalid)
		else $error("free_left does not match count");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!exec_go |=> $stable(free_count_q))
		else $error("count changed outside write-back");

	a_no_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == CTL_EXEC) |-> !s_tready)
		else $error("request taken while one is in flight");

endmodule
